// ===== hw/rtl/dtwr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helpers of the two-way ranging responder.
package dtwr_pkg;

  localparam int STAMP_BITS = 40;
  localparam int TIME_BITS  = 40;
  localparam int IVL_BITS   = 32;
  localparam int CNT_BITS   = 32;
  localparam int IDLE_BITS  = 16;
  localparam int ID_BITS    = 8;
  localparam int CFG_BITS   = 16;

  localparam logic [ID_BITS-1:0]   OWN_ID_RST   = 8'd8;
  localparam logic [IDLE_BITS-1:0] IDLE_LIM_RST = 16'd30000;
  localparam logic [7:0]           POLL_STAGE_NUM  = 8'd1;
  localparam logic [7:0]           FINAL_STAGE_NUM = 8'd3;

  typedef logic [STAMP_BITS-1:0] stamp_t;

  typedef enum logic [1:0] {
    CMD_FRAME   = 2'd0,
    CMD_TX_DONE = 2'd1,
    CMD_TICK    = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_REARM   = 3'd1,
    ACT_RESPOND = 3'd2,
    ACT_ERROR   = 3'd3,
    ACT_TIMING  = 3'd4,
    ACT_RESTART = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_POLL   = 2'd0,
    ST_TXDONE = 2'd1,
    ST_FINAL  = 2'd2
  } stage_t;

  typedef enum logic {
    CFG_OWN_ID   = 1'b0,
    CFG_IDLE_LIM = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]           command;
    logic                 rx_ok;
    logic                 error_frame;
    logic [ID_BITS-1:0]   dest_id;
    logic [7:0]           msg_stage;
    logic [TIME_BITS-1:0] rx_time;
    logic [TIME_BITS-1:0] tx_time;
  } item_t;

  typedef struct packed {
    stage_t                stage;
    stamp_t                request_stamp;
    stamp_t                response_stamp;
    logic [IVL_BITS-1:0]   reply_interval;
    logic [IDLE_BITS-1:0]  idle_ms;
    logic [CNT_BITS-1:0]   request_count;
    logic [CNT_BITS-1:0]   success_count;
    logic [CNT_BITS-1:0]   error_frame_count;
    logic [CNT_BITS-1:0]   timeout_count;
  } state_t;

  typedef struct packed {
    action_t             action;
    logic [IVL_BITS-1:0] round_time;
    logic [IVL_BITS-1:0] reply_time;
    stage_t              protocol_stage;
    logic [CNT_BITS-1:0] request_total;
    logic [CNT_BITS-1:0] success_total;
    logic [CNT_BITS-1:0] error_total;
    logic [CNT_BITS-1:0] timeouts;
  } result_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   own_id;
    logic [IDLE_BITS-1:0] idle_limit;
  } cfg_t;

  // Bring a timestamp port value to the internal stamp width.
  function automatic stamp_t to_stamp(input logic [TIME_BITS-1:0] t);
    logic [63:0] wide;
    wide = 64'(t);
    return wide[STAMP_BITS-1:0];
  endfunction

  // Wrapping stamp difference, low bits only.
  function automatic logic [IVL_BITS-1:0] stamp_diff(input stamp_t later,
                                                     input stamp_t earlier);
    stamp_t d;
    d = later - earlier;
    return d[IVL_BITS-1:0];
  endfunction

endpackage

// ===== hw/rtl/ds_twr_responder.sv =====
`timescale 1ns / 1ps
// Top level of the double-sided two-way ranging responder.
//
// Usage: each input item is one event. in_command selects a received frame
// (with rx_ok, error_frame, dest_id, msg_stage and rx_time), the transmit-done
// of our stage-2 response (with tx_time), or a one millisecond tick. Every
// accepted item gives exactly one result item carrying the action to take,
// the round and reply intervals (nonzero only with timing info), the
// protocol stage after the event and the four wrapping counters.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low. The configuration port writes own_id (index 0) and the inactivity
// limit (index 1) with cfg_we; the user writes them only while no item is in
// flight, which the block itself does not enforce. An accepted item waits in
// the input register, then one pass of decision logic updates the protocol
// state and loads the result register, which raises out_valid. One item is
// accepted per cycle sustained while the receiver does not stall, since each
// pass sees the state left by the item before it. When the receiver stalls,
// the held result stays put, one more item can wait in the input register,
// and then in_stall rises.
// Synchronous reset clears all protocol state and counters and restores
// own_id to 8 and the inactivity limit to 30000 ms.
module ds_twr_responder (
  input  logic        clk,
  input  logic        rst_n,
  // configuration port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [dtwr_pkg::CFG_BITS-1:0] cfg_data,
  // event channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic        in_rx_ok,
  input  logic        in_error_frame,
  input  logic [7:0]  in_dest_id,
  input  logic [7:0]  in_msg_stage,
  input  logic [39:0] in_rx_time,
  input  logic [39:0] in_tx_time,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic signed [31:0] out_round_time,
  output logic signed [31:0] out_reply_time,
  output logic [1:0]  out_protocol_stage,
  output logic [31:0] out_request_total,
  output logic [31:0] out_success_total,
  output logic [31:0] out_error_total,
  output logic [31:0] out_timeouts
);

  dtwr_pkg::cfg_t    cfg_r;
  dtwr_pkg::item_t   in_item_r;
  logic              in_valid_r;
  dtwr_pkg::state_t  state_r;
  dtwr_pkg::state_t  state_nxt;
  dtwr_pkg::result_t res_nxt;
  dtwr_pkg::result_t out_res_r;
  logic              out_valid_r;
  logic              advance;
  logic              in_take;

  // The decision pass runs when an item waits and the result register is
  // free or is being emptied this cycle.
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_id     <= dtwr_pkg::OWN_ID_RST;
      cfg_r.idle_limit <= dtwr_pkg::IDLE_LIM_RST;
    end else if (cfg_we) begin
      unique case (dtwr_pkg::cfg_idx_t'(cfg_index))
        dtwr_pkg::CFG_OWN_ID:   cfg_r.own_id     <= cfg_data[dtwr_pkg::ID_BITS-1:0];
        dtwr_pkg::CFG_IDLE_LIM: cfg_r.idle_limit <= cfg_data[dtwr_pkg::IDLE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.command     <= in_command;
      in_item_r.rx_ok       <= in_rx_ok;
      in_item_r.error_frame <= in_error_frame;
      in_item_r.dest_id     <= in_dest_id;
      in_item_r.msg_stage   <= in_msg_stage;
      in_item_r.rx_time     <= in_rx_time;
      in_item_r.tx_time     <= in_tx_time;
    end
  end

  dtwr_step u_step (
    .item_i (in_item_r),
    .st_i   (state_r),
    .cfg_i  (cfg_r),
    .st_o   (state_nxt),
    .res_o  (res_nxt)
  );

  // Protocol state and counters advance once per processed item. The
  // all-zero reset value is the await-poll stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_action         = out_res_r.action;
  assign out_round_time     = $signed(out_res_r.round_time);
  assign out_reply_time     = $signed(out_res_r.reply_time);
  assign out_protocol_stage = out_res_r.protocol_stage;
  assign out_request_total  = out_res_r.request_total;
  assign out_success_total  = out_res_r.success_total;
  assign out_error_total    = out_res_r.error_total;
  assign out_timeouts       = out_res_r.timeouts;

  // Intervals are only reported together with timing info.
  a_intervals_only_with_timing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.action != dtwr_pkg::ACT_TIMING |->
      out_res_r.round_time == '0 && out_res_r.reply_time == '0)
    else $error("interval reported without timing info");

  // A restart leaves every counter and the stage cleared.
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_nxt.action == dtwr_pkg::ACT_RESTART |=>
      state_r.stage == dtwr_pkg::ST_POLL && state_r.request_count == '0 &&
      state_r.success_count == '0 && state_r.error_frame_count == '0 &&
      state_r.timeout_count == '0 && state_r.idle_ms == '0)
    else $error("restart did not clear state");

  // The success counter moves only on a completed exchange or a restart.
  a_success_only_on_timing: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_nxt.action != dtwr_pkg::ACT_TIMING &&
      res_nxt.action != dtwr_pkg::ACT_RESTART |->
      state_nxt.success_count == state_r.success_count)
    else $error("success counter changed without completed exchange");

  // State holds whenever no item is processed.
  a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("protocol state changed without an item");

  // A stage-2 response always leaves the block awaiting transmit-done.
  a_respond_stage: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_nxt.action == dtwr_pkg::ACT_RESPOND |->
      res_nxt.protocol_stage == dtwr_pkg::ST_TXDONE)
    else $error("response sent without moving to await transmit-done");

endmodule

// ===== hw/rtl/dtwr_step.sv =====
`timescale 1ns / 1ps
// Decision logic for one event: next protocol state and the result item.
module dtwr_step (
  input  dtwr_pkg::item_t  item_i,
  input  dtwr_pkg::state_t st_i,
  input  dtwr_pkg::cfg_t   cfg_i,
  output dtwr_pkg::state_t st_o,
  output dtwr_pkg::result_t res_o
);

  dtwr_pkg::stage_t          stage_cur;
  dtwr_pkg::state_t          nxt;
  dtwr_pkg::action_t         action;
  logic [dtwr_pkg::IVL_BITS-1:0] round_v;
  logic [dtwr_pkg::IVL_BITS-1:0] reply_v;
  logic                      polling;
  logic [7:0]                want;

  always_comb begin
    // A stray stage code behaves as awaiting poll.
    if (st_i.stage == dtwr_pkg::ST_TXDONE || st_i.stage == dtwr_pkg::ST_FINAL) begin
      stage_cur = st_i.stage;
    end else begin
      stage_cur = dtwr_pkg::ST_POLL;
    end
    polling = (stage_cur == dtwr_pkg::ST_POLL);
    want    = polling ? dtwr_pkg::POLL_STAGE_NUM : dtwr_pkg::FINAL_STAGE_NUM;

    nxt       = st_i;
    nxt.stage = stage_cur;
    action    = dtwr_pkg::ACT_NONE;
    round_v   = '0;
    reply_v   = '0;

    unique case (item_i.command)
      dtwr_pkg::CMD_TICK: begin
        if (st_i.idle_ms >= cfg_i.idle_limit) begin
          nxt       = '0;
          nxt.stage = dtwr_pkg::ST_POLL;
          action    = dtwr_pkg::ACT_RESTART;
        end else begin
          nxt.idle_ms = st_i.idle_ms + 1'b1;
        end
      end
      dtwr_pkg::CMD_TX_DONE: begin
        if (stage_cur == dtwr_pkg::ST_TXDONE) begin
          nxt.response_stamp = dtwr_pkg::to_stamp(item_i.tx_time);
          nxt.reply_interval = dtwr_pkg::stamp_diff(dtwr_pkg::to_stamp(item_i.tx_time),
                                                    st_i.request_stamp);
          nxt.stage          = dtwr_pkg::ST_FINAL;
        end
      end
      dtwr_pkg::CMD_FRAME: begin
        if (stage_cur != dtwr_pkg::ST_TXDONE) begin
          if (polling) begin
            nxt.request_count = st_i.request_count + 1'b1;
          end
          if (!item_i.rx_ok) begin
            nxt.timeout_count = st_i.timeout_count + 1'b1;
            nxt.stage         = dtwr_pkg::ST_POLL;
            action            = dtwr_pkg::ACT_REARM;
          end else if (item_i.error_frame) begin
            nxt.error_frame_count = st_i.error_frame_count + 1'b1;
            nxt.stage             = dtwr_pkg::ST_POLL;
            action                = dtwr_pkg::ACT_REARM;
          end else if (item_i.dest_id != cfg_i.own_id) begin
            nxt.stage = dtwr_pkg::ST_POLL;
            action    = dtwr_pkg::ACT_REARM;
          end else if (item_i.msg_stage != want) begin
            nxt.error_frame_count = st_i.error_frame_count + 1'b1;
            nxt.stage             = dtwr_pkg::ST_POLL;
            action                = dtwr_pkg::ACT_ERROR;
          end else if (polling) begin
            nxt.request_stamp  = dtwr_pkg::to_stamp(item_i.rx_time);
            nxt.reply_interval = '0;
            nxt.stage          = dtwr_pkg::ST_TXDONE;
            action             = dtwr_pkg::ACT_RESPOND;
          end else begin
            round_v           = dtwr_pkg::stamp_diff(dtwr_pkg::to_stamp(item_i.rx_time),
                                                     st_i.response_stamp);
            reply_v           = st_i.reply_interval;
            nxt.success_count = st_i.success_count + 1'b1;
            nxt.idle_ms       = '0;
            nxt.stage         = dtwr_pkg::ST_POLL;
            action            = dtwr_pkg::ACT_TIMING;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign st_o = nxt;

  always_comb begin
    res_o.action         = action;
    res_o.round_time     = round_v;
    res_o.reply_time     = reply_v;
    res_o.protocol_stage = nxt.stage;
    res_o.request_total  = nxt.request_count;
    res_o.success_total  = nxt.success_count;
    res_o.error_total    = nxt.error_frame_count;
    res_o.timeouts       = nxt.timeout_count;
  end

endmodule
